// File: rtl/bbc_pkg.sv
// Shared types and constants for the clipped 3x3 box blur.
package bbc_pkg;

    localparam int unsigned MaxSize = 1024;
    localparam int unsigned SizeBits = 11;
    localparam int unsigned CoordBits = 10;
    localparam int unsigned ChanBits = 16;
    localparam int unsigned SumBits = 20;
    localparam int unsigned PixBits = 3 * ChanBits;

    typedef struct packed {
        logic [ChanBits-1:0] in_red;
        logic [ChanBits-1:0] in_green;
        logic [ChanBits-1:0] in_blue;
    } t_in_beat;

    typedef struct packed {
        logic [CoordBits-1:0] out_row;
        logic [CoordBits-1:0] out_col;
        logic [ChanBits-1:0]  out_red;
        logic [ChanBits-1:0]  out_green;
        logic [ChanBits-1:0]  out_blue;
        logic                 last_of_run;
    } t_out_beat;

    // One job handed from the front to the back: a 3x3 window snapshot plus
    // the position of the pixel that completed it.
    typedef struct packed {
        logic [8:0][PixBits-1:0] win;
        logic [CoordBits-1:0]    row;
        logic [CoordBits-1:0]    col;
        logic                    last_row;
        logic                    last_col;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

// File: rtl/bbc_front.sv
// Front: line stores, window shift, and raster position tracking.
module bbc_front #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbc_pkg::SizeBits-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bbc_pkg::t_in_beat             i_data,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output bbc_pkg::t_job                 o_job
);
    localparam int unsigned AW = $clog2(bbc_pkg::MaxSize);
    localparam int unsigned CB = bbc_pkg::ChanBits;
    localparam int unsigned PB = bbc_pkg::PixBits;

    logic [PB-1:0] r_older [bbc_pkg::MaxSize];
    logic [PB-1:0] r_newer [bbc_pkg::MaxSize];

    logic [bbc_pkg::SizeBits-1:0] r_size;
    logic [bbc_pkg::SizeBits-1:0] eff_n;
    logic [bbc_pkg::CoordBits-1:0] r_row, r_col, n_row, n_col;
    logic [8:0][PB-1:0] r_win;
    logic r_phase;               // 1 while the stored lines are being written
    logic [PB-1:0] r_px, r_rd_old, r_rd_new;
    logic [bbc_pkg::CoordBits-1:0] r_prow, r_pcol;
    logic r_job_valid;
    logic [bbc_pkg::SizeBits-1:0] lim;
    logic [bbc_pkg::SizeBits-1:0] row_w, col_w;
    logic [8:0][PB-1:0] n_win;
    logic [PB-1:0] px_in;
    logic [CB-1:0] cmask;
    logic emit;

    assign cmask = CB'((32'd1 << CHANNEL_BITS) - 32'd1);
    assign px_in = {i_data.in_blue & cmask, i_data.in_green & cmask,
                    i_data.in_red & cmask};

    always_comb begin
        if (r_size == '0) begin
            eff_n = bbc_pkg::SizeBits'(1);
        end else if (r_size > bbc_pkg::SizeBits'(bbc_pkg::MaxSize)) begin
            eff_n = bbc_pkg::SizeBits'(bbc_pkg::MaxSize);
        end else begin
            eff_n = r_size;
        end
    end
    assign lim = eff_n - bbc_pkg::SizeBits'(1);
    assign row_w = {1'b0, r_row};
    assign col_w = {1'b0, r_col};

    // Accept outside the write phase, when the job slot is free or being taken.
    assign o_ready = !r_phase && (!r_job_valid || i_job_ready);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (col_w >= lim) begin
            n_col = '0;
            n_row = (row_w >= lim) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            n_win[x*3+0] = r_win[x*3+1];
            n_win[x*3+1] = r_win[x*3+2];
        end
        n_win[2] = r_rd_old;
        n_win[5] = r_rd_new;
        n_win[8] = r_px;
    end

    // A window completes when the row and column reach 2 or the far edge.
    assign emit = (r_prow >= bbc_pkg::CoordBits'(2) || {1'b0, r_prow} == lim)
               && (r_pcol >= bbc_pkg::CoordBits'(2) || {1'b0, r_pcol} == lim);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rd_old <= r_older[r_col[AW-1:0]];
            r_rd_new <= r_newer[r_col[AW-1:0]];
            r_px <= px_in;
            r_prow <= r_row;
            r_pcol <= r_col;
        end
        if (r_phase) begin
            r_older[r_pcol[AW-1:0]] <= r_rd_new;
            r_newer[r_pcol[AW-1:0]] <= r_px;
            o_job.win <= n_win;
            o_job.row <= r_prow;
            o_job.col <= r_pcol;
            o_job.last_row <= ({1'b0, r_prow} == lim);
            o_job.last_col <= ({1'b0, r_pcol} == lim);
        end
        if (!i_rst_n) begin
            r_size <= bbc_pkg::SizeBits'(512);
            r_row <= '0;
            r_col <= '0;
            r_phase <= 1'b0;
            r_job_valid <= 1'b0;
            r_win <= '0;
        end else begin
            if (r_phase) begin
                r_win <= n_win;
            end
            if (r_job_valid && i_job_ready) begin
                r_job_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
                r_row <= '0;
                r_col <= '0;
            end else if (i_valid && o_ready) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_valid && o_ready) begin
                r_phase <= 1'b1;
            end else if (r_phase) begin
                r_phase <= 1'b0;
                if (emit) begin
                    r_job_valid <= 1'b1;
                end
            end
        end
    end

    assign o_job_valid = r_job_valid;
endmodule

// File: rtl/bbc_back.sv
// Back: walks the windows of one job, sums, divides and emits beats.
module bbc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  bbc_pkg::t_job        i_job,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bbc_pkg::t_out_beat   o_data
);
    localparam int unsigned CB = bbc_pkg::ChanBits;
    localparam int unsigned SB = bbc_pkg::SumBits;
    localparam int unsigned RB = 21;
    localparam int unsigned PW = SB + RB;

    bbc_pkg::t_back_state r_state, n_state;
    bbc_pkg::t_job r_job;
    logic [1:0] r_ai, r_bi, r_ahi, r_bhi, r_blo;
    logic [2:0][SB-1:0] r_sum, n_sum;
    logic [1:0] rows, cols;
    logic [3:0] div;
    logic [RB-1:0] recip;
    logic [4:0] shamt;
    logic [PW-1:0] prod [3];
    logic [2:0][CB-1:0] r_q, n_q;
    logic r_ovalid;
    bbc_pkg::t_out_beat r_out;
    logic is_last;

    // Window rows span r_ai..2 of the job, columns r_bi..2.
    assign rows = 2'd3 - r_ai;
    assign cols = 2'd3 - r_bi;
    assign div = {2'b00, rows} * {2'b00, cols};
    assign is_last = (r_ai == r_ahi) && (r_bi == r_bhi);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = '0;
            for (int x = 0; x < 3; x++) begin
                for (int y = 0; y < 3; y++) begin
                    if (2'(x) >= r_ai && 2'(y) >= r_bi) begin
                        n_sum[k] = n_sum[k] + SB'(r_job.win[x*3+y][k*CB +: CB]);
                    end
                end
            end
        end
    end

    // Divide by multiplying with a rounded-up reciprocal, exact for any 20-bit sum.
    always_comb begin
        case (div)
            4'd2: begin
                recip = RB'(1);
                shamt = 5'd1;
            end
            4'd3: begin
                recip = RB'(22'h155556);
                shamt = 5'd22;
            end
            4'd4: begin
                recip = RB'(1);
                shamt = 5'd2;
            end
            4'd6: begin
                recip = RB'(22'h155556);
                shamt = 5'd23;
            end
            4'd9: begin
                recip = RB'(22'h1C71C8);
                shamt = 5'd24;
            end
            default: begin
                recip = RB'(1);
                shamt = 5'd0;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = PW'(r_sum[k]) * PW'(recip);
            n_q[k] = CB'(prod[k] >> shamt);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bbc_pkg::S_IDLE: if (i_job_valid) n_state = bbc_pkg::S_SUM;
            bbc_pkg::S_SUM: n_state = bbc_pkg::S_DIV;
            bbc_pkg::S_DIV: n_state = bbc_pkg::S_OUT;
            bbc_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = is_last ? bbc_pkg::S_IDLE : bbc_pkg::S_SUM;
                end
            end
            default: n_state = bbc_pkg::S_IDLE;
        endcase
    end

    assign o_job_ready = (r_state == bbc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        case (r_state)
            bbc_pkg::S_IDLE: begin
                r_job <= i_job;
                // Windows starting at rows 0..2 back; far edges add more.
                r_ahi <= i_job.last_row ? 2'd2 : 2'd0;
                r_ai <= (i_job.row < 10'd2) ? 2'(2'd2 - i_job.row[1:0]) : 2'd0;
                r_bi <= (i_job.col < 10'd2) ? 2'(2'd2 - i_job.col[1:0]) : 2'd0;
                r_blo <= (i_job.col < 10'd2) ? 2'(2'd2 - i_job.col[1:0]) : 2'd0;
                r_bhi <= i_job.last_col ? 2'd2 : 2'd0;
                if (i_job.row < 10'd2 && !i_job.last_row) r_ahi <= 2'd0;
                if (i_job.col < 10'd2 && !i_job.last_col) r_bhi <= 2'd0;
            end
            bbc_pkg::S_SUM: begin
                r_sum <= n_sum;
            end
            bbc_pkg::S_DIV: begin
                r_q <= n_q;
            end
            bbc_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    r_out.out_row <= r_job.row - 10'(2'd2 - r_ai);
                    r_out.out_col <= r_job.col - 10'(2'd2 - r_bi);
                    r_out.out_red <= r_q[0];
                    r_out.out_green <= r_q[1];
                    r_out.out_blue <= r_q[2];
                    r_out.last_of_run <= is_last;
                    if (r_bi == r_bhi) begin
                        r_bi <= r_blo;
                        r_ai <= r_ai + 1'b1;
                    end else begin
                        r_bi <= r_bi + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bbc_pkg::S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;
endmodule

// File: rtl/box_blur_clipped_3x3.sv
// Top level of the clipped 3x3 box blur.
//  channel | signals                         | accepted when
//  in      | i_valid, o_ready, i_data        | i_valid && o_ready
//  out     | o_valid, i_ready, o_data        | o_valid && i_ready
//  cfg     | i_cfg_we, i_cfg_data            | i_cfg_we
// Each pixel is handled in the front as a line store read, then a write.
// The back takes a job while idle, then per result a sum, a reciprocal-multiply
// divide, then the output register, which waits on i_ready; up to nine per pixel.
// One job slot sits between front and back; input stalls while it is full.
// Reset clears size to 512 and the position to the frame start; line stores
// are not cleared.
module box_blur_clipped_3x3 #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbc_pkg::SizeBits-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bbc_pkg::t_in_beat             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bbc_pkg::t_out_beat            o_data
);
    logic job_valid, job_ready;
    bbc_pkg::t_job job;

    bbc_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_ready, .i_data,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    bbc_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready),
        .i_job(job), .o_valid, .i_ready, .o_data
    );
endmodule

// File: tb/tb.sv
// Testbench for box_blur_clipped_3x3: directed and random raster frames checked against a blur predictor.
`timescale 1ns / 100ps

module tb;

    localparam int LINE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 300;

    class blur_scoreboard;
        bbc_pkg::t_out_beat pending[$];
        int           errors;
        int unsigned  size_reg;
        int unsigned  row_pos;
        int unsigned  col_pos;
        logic [47:0]  older_line[LINE_DEPTH];
        logic [47:0]  newer_line[LINE_DEPTH];
        logic [47:0]  win[3][3];

        function new();
            errors = 0;
            size_reg = 512;
            row_pos = 0;
            col_pos = 0;
            foreach (win[x, y]) win[x][y] = '0;
            foreach (older_line[i]) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
        endfunction

        function void write_size(int unsigned v);
            size_reg = v & 11'h7ff;
            row_pos = 0;
            col_pos = 0;
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        endtask

        // Work out every window completed by this pixel.
        function void note_pixel(bbc_pkg::t_in_beat p);
            int unsigned n;
            int r, c, alo, ahi, blo, bhi, div, cnt;
            int unsigned sum_r, sum_g, sum_b;
            bbc_pkg::t_out_beat o;
            n = size_reg;
            if (n < 1) n = 1;
            if (n > LINE_DEPTH) n = LINE_DEPTH;
            if (row_pos >= n || col_pos >= n) begin
                row_pos = 0;
                col_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            cnt = 0;
            for (int x = 0; x < 3; x++) begin
                win[x][0] = win[x][1];
                win[x][1] = win[x][2];
            end
            win[0][2] = older_line[c];
            win[1][2] = newer_line[c];
            win[2][2] = {p.in_red, p.in_green, p.in_blue};
            older_line[c] = newer_line[c];
            newer_line[c] = win[2][2];
            alo = (r < 2) ? 0 : r - 2;
            ahi = (r == n - 1) ? r : r - 2;
            blo = (c < 2) ? 0 : c - 2;
            bhi = (c == n - 1) ? c : c - 2;
            for (int a = alo; a <= ahi; a++) begin
                for (int b = blo; b <= bhi; b++) begin
                    sum_r = 0;
                    sum_g = 0;
                    sum_b = 0;
                    for (int x = a; x <= r; x++) begin
                        for (int y = b; y <= c; y++) begin
                            sum_r += win[x - r + 2][y - c + 2][47:32];
                            sum_g += win[x - r + 2][y - c + 2][31:16];
                            sum_b += win[x - r + 2][y - c + 2][15:0];
                        end
                    end
                    div = (r - a + 1) * (c - b + 1);
                    o.out_row = a[9:0];
                    o.out_col = b[9:0];
                    o.out_red = 16'(sum_r / div);
                    o.out_green = 16'(sum_g / div);
                    o.out_blue = 16'(sum_b / div);
                    o.last_of_run = 1'b0;
                    pending.push_back(o);
                    cnt++;
                end
            end
            if (cnt > 0) pending[$].last_of_run = 1'b1;
            if (col_pos + 1 >= n) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        endfunction

        task check_beat(bbc_pkg::t_out_beat got);
            bbc_pkg::t_out_beat want;
            if (pending.size() == 0) begin
                report("unexpected beat, row", got.out_row, 0);
            end else begin
                want = pending.pop_front();
                if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
                if (got.out_col !== want.out_col) report("out_col", got.out_col, want.out_col);
                if (got.out_red !== want.out_red) report("out_red", got.out_red, want.out_red);
                if (got.out_green !== want.out_green)
                    report("out_green", got.out_green, want.out_green);
                if (got.out_blue !== want.out_blue)
                    report("out_blue", got.out_blue, want.out_blue);
                if (got.last_of_run !== want.last_of_run)
                    report("last_of_run", got.last_of_run, want.last_of_run);
            end
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [bbc_pkg::SizeBits-1:0] i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    bbc_pkg::t_in_beat            i_data;
    logic                         o_valid;
    logic                         i_ready;
    bbc_pkg::t_out_beat           o_data;

    blur_scoreboard sb;
    bit             quiet_mode;
    bit             hold_req;

    box_blur_clipped_3x3 u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task send_pixel(bbc_pkg::t_in_beat p);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= p;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(p);
    endtask

    function bbc_pkg::t_in_beat pick_pixel();
        bbc_pkg::t_in_beat p;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            default: p = {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        return p;
    endfunction

    // Drop valid and hold until every expected beat is out, then let the design settle.
    task drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task set_size(int unsigned v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[bbc_pkg::SizeBits-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_size(v);
    endtask

    task run_pixels(int count, bit quiet);
        quiet_mode = quiet;
        for (int i = 0; i < count; i++) send_pixel(pick_pixel());
        quiet_mode = 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        int w;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                w = 400;
                hold_req = 1'b0;
            end else begin
                w = quiet_mode ? 0 : $urandom_range(0, 10);
            end
            if (w > 0) begin
                i_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_beat(o_data);
        end
    end

    initial begin
        #5_000_000;
        $display("** box_blur_clipped_3x3: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        quiet_mode = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-pixel, 2x2 and 3x3 frames with channel extremes.
        set_size(1);
        send_pixel('0);
        send_pixel('1);
        send_pixel({16'hffff, 16'h0000, 16'h8000});
        send_pixel({16'h0001, 16'h7fff, 16'hffff});
        set_size(2);
        send_pixel('1);
        send_pixel('1);
        send_pixel('1);
        send_pixel({16'h0000, 16'hffff, 16'h0001});
        set_size(3);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? '1 : {3{16'(i * 7)}});

        // Out-of-range sizes act as the nearest legal one.
        set_size(0);
        run_pixels(20, 0);
        set_size(2047);
        run_pixels(12, 0);
        set_size(1024);
        run_pixels(12, 1);

        // Abandon a frame part way; the size write restarts it.
        set_size(5);
        run_pixels(13, 0);
        set_size(4);
        run_pixels(32, 0);
        set_size(7);
        hold_req = 1'b1;
        run_pixels(98, 1);
        set_size(6);
        run_pixels(72, 0);
        set_size(3);
        run_pixels(36, 1);
        set_size(2);
        run_pixels(8, 0);

        drain();
        if (sb.errors == 0) begin
            $display("** box_blur_clipped_3x3: PASSED **");
        end else begin
            $display("** box_blur_clipped_3x3: FAILED **");
        end
        $finish;
    end

endmodule
